@@ rtl/vps_pkg.sv @@
package vps_pkg;

    // Default number of pyramid levels below the full image.
    localparam int LEVELS_DEFAULT = 6;

    // Field widths.
    localparam int COORD_W   = 21;
    localparam int FRAC_W    = 4;
    localparam int MAG_W     = COORD_W - 1;
    localparam int SIZE_W    = 16;
    localparam int DEN_W     = SIZE_W + FRAC_W;
    localparam int REM_W     = (MAG_W > DEN_W) ? MAG_W : DEN_W;
    localparam int SCORE_W   = 25;
    localparam int NEWC_W    = 3;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Register values after reset.
    localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST = SIZE_W'(480);

    // Commands to the shared divider.
    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // Commands to the occupancy store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } occ_ctrl_t;

endpackage

@@ rtl/vps_if.sv @@
interface vps_cfg_if;
    import vps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface vps_point_if;
    import vps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface vps_result_if;
    import vps_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic [NEWC_W-1:0]  new_cells;

    modport source (output valid, output score, output new_cells, input ready);
    modport sink   (input valid, input score, input new_cells, output ready);
endinterface

@@ rtl/visibility_pyramid_score_core.sv @@
// Visibility pyramid score core.
// Configuration words arrive on cfg (index 0 is the image width, index 1 the
// image height, both in whole pixels); cfg is always ready and may only be
// written while no point is in flight. Each word on point carries one image
// point in signed pixels with four fraction bits. For every point one word
// leaves on result: the running weighted score of occupied pyramid cells and
// the number of levels in which this point hit a previously empty cell.
// One shared compare-subtract divider finds the finest cell on each axis,
// one quotient bit per cycle, and the occupancy memory is then visited with
// one read and one conditional write per level. An accepted point passes a
// divider load and steps for x, a load and steps for y, a setup state, a
// read and a check state per level, and a finish state that fills the output
// register before idle takes the next point. The pace is set by the
// divider steps and by the registered read of the occupancy memory. After
// reset the memory is cleared one cell per cycle; point is not ready during
// that sweep. The result is held in an output register. If the receiver
// stalls, a finished result waits for it, and the next point may already be
// accepted and worked on until its own result needs that register.
module visibility_pyramid_score_core #(
    parameter int LEVELS = vps_pkg::LEVELS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    vps_cfg_if.sink         cfg,
    vps_point_if.sink       point,
    vps_result_if.source    result
);
    import vps_pkg::*;

    localparam int CELLS    = ((1 << (2 * (LEVELS + 1))) - 4) / 3;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(LEVELS + 1);
    localparam int BASE_TOP = ((1 << (2 * LEVELS)) - 4) / 3;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DLOAD  = 3'd1;
    localparam logic [2:0] ST_DSTEP  = 3'd2;
    localparam logic [2:0] ST_OSETUP = 3'd3;
    localparam logic [2:0] ST_OREAD  = 3'd4;
    localparam logic [2:0] ST_OCHECK = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic [SIZE_W-1:0]         width_reg, height_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic                      axis_reg, axis_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [LEVELS-1:0]         cx_reg, cx_next;
    logic [LEVELS-1:0]         cy_reg, cy_next;
    logic [AW-1:0]             base_reg, base_next;
    logic [SCORE_W-1:0]        score_reg, score_next;
    logic [CW-1:0]             fresh_reg, fresh_next;
    logic                      out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0]        out_score_reg;
    logic [NEWC_W-1:0]         out_newc_reg;

    logic                      in_accept;
    logic                      out_load;
    logic signed [COORD_W-1:0] coord_sel;
    logic [SIZE_W-1:0]         size_sel;
    logic [MAG_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [LEVELS-1:0]         div_index;
    div_ctrl_t                 div_ctrl;
    occ_ctrl_t                 occ_ctrl;
    logic [AW-1:0]             cell_addr;
    logic                      cell_used;
    logic                      clearing;
    logic [CW-1:0]             side_log;

    assign cfg.ready   = 1'b1;
    assign point.ready = (state_reg == ST_IDLE) && !clearing;
    assign in_accept   = point.valid && point.ready;

    // Divider operands: a negative coordinate divides as zero, so it lands
    // in cell zero; an image size of zero counts as one pixel.
    always_comb
    begin
        coord_sel = axis_reg ? py_reg : px_reg;
        size_sel  = axis_reg ? height_reg : width_reg;
        div_num   = coord_sel[COORD_W-1] ? '0 : coord_sel[MAG_W-1:0];
        if (size_sel == '0)
        begin
            size_sel = SIZE_W'(1);
        end
        div_den = {size_sel, FRAC_W'(0)};
    end

    vps_div_unit #(
        .LEVELS (LEVELS)
    ) u_div (
        .clk   (clk),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (div_den),
        .index (div_index)
    );

    // During the level walk cnt_reg holds the level, the cell indexes have
    // already been halved down to it, and base_reg points at its first cell.
    assign side_log  = cnt_reg + CW'(1);
    assign cell_addr = base_reg + (AW'(cx_reg) << side_log) + AW'(cy_reg);

    vps_occ_store #(
        .LEVELS (LEVELS)
    ) u_occ (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (occ_ctrl),
        .addr     (cell_addr),
        .rd_data  (cell_used),
        .clearing (clearing)
    );

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        base_next      = base_reg;
        score_next     = score_reg;
        fresh_next     = fresh_reg;
        div_ctrl       = '0;
        occ_ctrl       = '0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    axis_next  = 1'b0;
                    state_next = ST_DLOAD;
                end
            end
            ST_DLOAD:
            begin
                div_ctrl.load = 1'b1;
                cnt_next      = '0;
                if (axis_reg)
                begin
                    // The x quotient is complete and about to be overwritten.
                    cx_next = div_index;
                end
                state_next = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                div_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + CW'(1);
                if (cnt_reg == CW'(LEVELS - 1))
                begin
                    if (!axis_reg)
                    begin
                        axis_next  = 1'b1;
                        state_next = ST_DLOAD;
                    end
                    else
                    begin
                        state_next = ST_OSETUP;
                    end
                end
            end
            ST_OSETUP:
            begin
                cy_next    = div_index;
                cnt_next   = CW'(LEVELS - 1);
                base_next  = AW'(BASE_TOP);
                fresh_next = '0;
                state_next = ST_OREAD;
            end
            ST_OREAD:
            begin
                occ_ctrl.rd_en = 1'b1;
                state_next     = ST_OCHECK;
            end
            ST_OCHECK:
            begin
                if (!cell_used)
                begin
                    occ_ctrl.wr_en = 1'b1;
                    score_next     = score_reg + (SCORE_W'(1) << {side_log, 1'b0});
                    fresh_next     = fresh_reg + CW'(1);
                end
                cx_next   = cx_reg >> 1;
                cy_next   = cy_reg >> 1;
                base_next = base_reg - (AW'(1) << {cnt_reg, 1'b0});
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_OREAD;
                end
            end
            ST_FINISH:
            begin
                // Wait here only while an earlier result is still unclaimed.
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            score_reg     <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= IMAGE_WIDTH_RST;
            height_reg    <= IMAGE_HEIGHT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            score_reg     <= score_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_IMAGE_WIDTH)
                begin
                    width_reg <= cfg.data;
                end
                else if (cfg.index == REG_IMAGE_HEIGHT)
                begin
                    height_reg <= cfg.data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            px_reg <= point.point_x;
            py_reg <= point.point_y;
        end
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        base_reg <= base_next;
        if (out_load)
        begin
            out_score_reg <= score_reg;
            out_newc_reg  <= NEWC_W'(fresh_reg);
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.score     = out_score_reg;
    assign result.new_cells = out_newc_reg;

endmodule

@@ rtl/vps_div_unit.sv @@
module vps_div_unit #(
    parameter int LEVELS = vps_pkg::LEVELS_DEFAULT
) (
    input  logic                        clk,
    input  vps_pkg::div_ctrl_t          ctrl,
    input  logic [vps_pkg::MAG_W-1:0]   num,
    input  logic [vps_pkg::DEN_W-1:0]   den,
    output logic [LEVELS-1:0]           index
);
    import vps_pkg::*;

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [LEVELS-1:0] quo_reg, quo_next;
    logic              over_reg, over_next;
    logic [REM_W:0]    trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    // One compare-subtract serves both the range check at load and each
    // restoring division step.
    always_comb
    begin
        trial     = ctrl.load ? (REM_W+1)'(num) : {rem_reg, 1'b0};
        diff      = {1'b0, trial} - (REM_W+2)'(den);
        ge        = !diff[REM_W+1];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        over_next = over_reg;
        if (ctrl.load)
        begin
            rem_next  = REM_W'(num);
            quo_next  = '0;
            over_next = ge;
        end
        else if (ctrl.step)
        begin
            rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            quo_next = LEVELS'({quo_reg, ge});
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        over_reg <= over_next;
    end

    // A numerator at or above the divisor saturates to the last cell.
    assign index = over_reg ? '1 : quo_reg;

endmodule

@@ rtl/vps_occ_store.sv @@
module vps_occ_store #(
    parameter int LEVELS = vps_pkg::LEVELS_DEFAULT,
    localparam int CELLS = ((1 << (2 * (LEVELS + 1))) - 4) / 3,
    localparam int AW    = $clog2(CELLS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vps_pkg::occ_ctrl_t ctrl,
    input  logic [AW-1:0]      addr,
    output logic               rd_data,
    output logic               clearing
);
    import vps_pkg::*;

    logic          mem [CELLS];
    logic [AW-1:0] clr_cnt_reg;
    logic          clearing_reg;
    logic          rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_bit;

    // After reset every cell is written to zero, one per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == AW'(CELLS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    always_comb
    begin
        wr_en   = clearing_reg | ctrl.wr_en;
        wr_addr = clearing_reg ? clr_cnt_reg : addr;
        wr_bit  = !clearing_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule
